[hdl/rtt_pkg.sv]
// Shared widths, command and status codes and the result type of the route table.
package rtt_pkg;

  localparam int CMD_W        = 3;
  localparam int FIELD_ADDR_W = 8;
  localparam int HOP_W        = 8;
  localparam int FIELD_PORT_W = 4;
  localparam int STATUS_W     = 2;
  localparam int MY_ADDR_W    = 8;
  localparam int PATHS_W      = 2;

  // Number of paths held for one destination
  localparam logic [PATHS_W-1:0] PATHS_NONE = 2'd0;
  localparam logic [PATHS_W-1:0] PATHS_ONE  = 2'd1;
  localparam logic [PATHS_W-1:0] PATHS_TWO  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT        = 3'd0,
    CMD_REGISTER    = 3'd1,
    CMD_REMOVE_PORT = 3'd2,
    CMD_UPDATE      = 3'd3,
    CMD_FETCH       = 3'd4,
    CMD_CLEAR_BL    = 3'd5,
    CMD_QUERY       = 3'd6,
    CMD_REMOVE_ADDR = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_IGNORED   = 2'd1,
    STAT_NO_ROUTE  = 2'd2,
    STAT_NO_NBR    = 2'd3
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [FIELD_PORT_W-1:0] out_port;
    logic                    is_blacklisted;
  } result_t;

endpackage

[hdl/rtt_if.sv]
// Request, result and configuration channel interfaces of the route table.
interface rtt_req_if;
  logic                              valid;
  logic                              ready;
  logic [rtt_pkg::CMD_W-1:0]         command;
  logic [rtt_pkg::FIELD_ADDR_W-1:0]  target_address;
  logic [rtt_pkg::FIELD_ADDR_W-1:0]  next_hop;
  logic [rtt_pkg::HOP_W-1:0]         hop_count;
  logic [rtt_pkg::FIELD_PORT_W-1:0]  port;

  modport source (output valid, command, target_address, next_hop, hop_count, port,
                  input ready);
  modport sink   (input valid, command, target_address, next_hop, hop_count, port,
                  output ready);
endinterface

interface rtt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rtt_pkg::STATUS_W-1:0]      status;
  logic [rtt_pkg::FIELD_PORT_W-1:0]  out_port;
  logic                              is_blacklisted;

  modport source (output valid, status, out_port, is_blacklisted, input ready);
  modport sink   (input valid, status, out_port, is_blacklisted, output ready);
endinterface

interface rtt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rtt_pkg::MY_ADDR_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/rtt_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [2**AW];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/rtt_ctrl.sv]
// Command sequencer: reads, modifies and writes back the route and neighbour memories.
module rtt_ctrl #(
  parameter int ADDR_BITS = 8,
  parameter int PORT_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rtt_pkg::MY_ADDR_W-1:0] my_address,
  rtt_req_if.sink                       req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rtt_pkg::result_t              res
);

  typedef struct packed {
    logic [ADDR_BITS-1:0]          first;
    logic [rtt_pkg::HOP_W-1:0]     first_cost;
    logic [ADDR_BITS-1:0]          second;
    logic [rtt_pkg::HOP_W-1:0]     second_cost;
    logic [rtt_pkg::PATHS_W-1:0]   paths;
  } route_t;

  typedef struct packed {
    logic                 black;
    logic                 valid;
    logic [PORT_BITS-1:0] port;
  } nbr_t;

  localparam int ROUTE_W = $bits(route_t);
  localparam int NBR_W   = $bits(nbr_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_FETCH,
    S_SCAN,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ADDR_BITS-1:0]     idx_r, idx_nxt;
  logic [ADDR_BITS-1:0]     wb_addr_r, wb_addr_nxt;
  logic                     pend_r, pend_nxt;
  logic                     stop_r, stop_nxt;
  logic                     install_r, install_nxt;
  logic                     sweep_nbr_r, sweep_nbr_nxt;
  rtt_pkg::cmd_t            cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0]     tgt_r, tgt_nxt;
  logic [ADDR_BITS-1:0]     nxt_hop_r, nxt_hop_nxt;
  logic [rtt_pkg::HOP_W-1:0] hop_r, hop_nxt;
  logic [PORT_BITS-1:0]     port_r, port_nxt;
  logic [ADDR_BITS-1:0]     rem_r, rem_nxt;
  rtt_pkg::result_t         res_r, res_nxt;

  logic                     rt_rd_en, rt_wr_en;
  logic [ADDR_BITS-1:0]     rt_rd_addr, rt_wr_addr;
  logic [ROUTE_W-1:0]       rt_rd_q;
  route_t                   rt_q, rt_wr_data;

  logic                     nb_rd_en, nb_wr_en;
  logic [ADDR_BITS-1:0]     nb_rd_addr, nb_wr_addr;
  logic [NBR_W-1:0]         nb_rd_q;
  nbr_t                     nb_q, nb_wr_data;

  logic                     accept;
  logic                     scan_hit;
  logic [ADDR_BITS-1:0]     self_addr;
  route_t                   self_route;

  // Apply one advertised route under the two-path rules
  function automatic route_t route_update(route_t r, logic [ADDR_BITS-1:0] n,
                                          logic [rtt_pkg::HOP_W-1:0] h);
    route_t o;
    o = r;
    if (r.paths == rtt_pkg::PATHS_NONE) begin
      o.first      = n;
      o.first_cost = h;
      o.paths      = rtt_pkg::PATHS_ONE;
    end else if (r.first_cost > h) begin
      if (r.first == n) begin
        o.first_cost = h;
      end else begin
        o.second      = r.first;
        o.second_cost = r.first_cost;
        o.first       = n;
        o.first_cost  = h;
        o.paths       = rtt_pkg::PATHS_TWO;
      end
    end else if (r.paths == rtt_pkg::PATHS_TWO) begin
      if (r.second_cost > h) begin
        o.second      = n;
        o.second_cost = h;
      end
    end else if (r.first != n) begin
      o.second      = n;
      o.second_cost = h;
      o.paths       = rtt_pkg::PATHS_TWO;
    end
    return o;
  endfunction

  // Drop routes to or via a removed address, promoting the backup hop
  function automatic route_t route_drop(route_t r, logic [ADDR_BITS-1:0] d,
                                        logic [ADDR_BITS-1:0] rem);
    route_t o;
    o = r;
    if (r.paths != rtt_pkg::PATHS_NONE) begin
      if (d == rem) begin
        o.paths = rtt_pkg::PATHS_NONE;
      end else if (r.first == rem) begin
        if (r.paths == rtt_pkg::PATHS_ONE) begin
          o.paths = rtt_pkg::PATHS_NONE;
        end else begin
          o.first      = r.second;
          o.first_cost = r.second_cost;
          o.paths      = rtt_pkg::PATHS_ONE;
        end
      end else if (r.paths == rtt_pkg::PATHS_TWO && r.second == rem) begin
        o.paths = rtt_pkg::PATHS_ONE;
      end
    end
    return o;
  endfunction

  // Route memory
  rtt_ram #(.WIDTH(ROUTE_W), .AW(ADDR_BITS)) u_route_ram (
    .clk     (clk),
    .rd_en   (rt_rd_en),
    .rd_addr (rt_rd_addr),
    .rd_data (rt_rd_q),
    .wr_en   (rt_wr_en),
    .wr_addr (rt_wr_addr),
    .wr_data (ROUTE_W'(rt_wr_data))
  );

  // Neighbour and blacklist memory
  rtt_ram #(.WIDTH(NBR_W), .AW(ADDR_BITS)) u_nbr_ram (
    .clk     (clk),
    .rd_en   (nb_rd_en),
    .rd_addr (nb_rd_addr),
    .rd_data (nb_rd_q),
    .wr_en   (nb_wr_en),
    .wr_addr (nb_wr_addr),
    .wr_data (NBR_W'(nb_wr_data))
  );

  assign rt_q      = route_t'(rt_rd_q);
  assign nb_q      = nbr_t'(nb_rd_q);
  assign accept    = req.valid && req.ready;
  assign req.ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign self_addr = ADDR_BITS'(my_address);
  assign scan_hit  = pend_r && nb_q.valid && (nb_q.port == port_r);

  always_comb begin
    self_route            = '0;
    self_route.first      = self_addr;
    self_route.first_cost = '0;
    self_route.paths      = rtt_pkg::PATHS_ONE;
  end

  // Next state, memory accesses and result
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wb_addr_nxt   = wb_addr_r;
    pend_nxt      = pend_r;
    stop_nxt      = stop_r;
    install_nxt   = install_r;
    sweep_nbr_nxt = sweep_nbr_r;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    nxt_hop_nxt   = nxt_hop_r;
    hop_nxt       = hop_r;
    port_nxt      = port_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;

    rt_rd_en   = 1'b0;
    rt_rd_addr = idx_r;
    rt_wr_en   = 1'b0;
    rt_wr_addr = idx_r;
    rt_wr_data = '0;
    nb_rd_en   = 1'b0;
    nb_rd_addr = idx_r;
    nb_wr_en   = 1'b0;
    nb_wr_addr = idx_r;
    nb_wr_data = '0;

    case (state_r)
      // Sweep both memories clear, installing the self route on init
      S_CLEAR: begin
        rt_wr_en = 1'b1;
        nb_wr_en = 1'b1;
        if (install_r && idx_r == self_addr) begin
          rt_wr_data = self_route;
        end
        idx_nxt = idx_r + ADDR_BITS'(1);
        if (&idx_r) begin
          idx_nxt = '0;
          if (install_r) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Take a request and start the point reads at its target
      S_IDLE: begin
        rt_rd_addr = ADDR_BITS'(req.target_address);
        nb_rd_addr = ADDR_BITS'(req.target_address);
        rt_rd_en   = accept;
        nb_rd_en   = accept;
        if (accept) begin
          cmd_nxt                = rtt_pkg::cmd_t'(req.command);
          tgt_nxt                = ADDR_BITS'(req.target_address);
          nxt_hop_nxt            = ADDR_BITS'(req.next_hop);
          hop_nxt                = req.hop_count;
          port_nxt               = PORT_BITS'(req.port);
          res_nxt.status         = rtt_pkg::STAT_OK;
          res_nxt.out_port       = '0;
          res_nxt.is_blacklisted = 1'b0;
          idx_nxt                = '0;
          pend_nxt               = 1'b0;
          stop_nxt               = 1'b0;
          install_nxt            = 1'b0;
          case (rtt_pkg::cmd_t'(req.command))
            rtt_pkg::CMD_INIT: begin
              install_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            rtt_pkg::CMD_CLEAR_BL: begin
              sweep_nbr_nxt = 1'b1;
              state_nxt     = S_SWEEP;
            end
            rtt_pkg::CMD_REMOVE_PORT: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_EVAL;
            end
          endcase
        end
      end

      // Evaluate the entries read at the target
      S_EVAL: begin
        nb_wr_addr = tgt_r;
        rt_wr_addr = tgt_r;
        state_nxt  = S_DONE;
        case (cmd_r)
          rtt_pkg::CMD_REGISTER: begin
            if (nb_q.black || nb_q.valid) begin
              res_nxt.status = rtt_pkg::STAT_IGNORED;
            end else begin
              nb_wr_en         = 1'b1;
              nb_wr_data.black = 1'b0;
              nb_wr_data.valid = 1'b1;
              nb_wr_data.port  = port_r;
            end
          end
          rtt_pkg::CMD_UPDATE: begin
            if (nb_q.black) begin
              res_nxt.status = rtt_pkg::STAT_IGNORED;
            end else begin
              rt_wr_en   = 1'b1;
              rt_wr_data = route_update(rt_q, nxt_hop_r, hop_r);
            end
          end
          rtt_pkg::CMD_FETCH: begin
            if (rt_q.paths == rtt_pkg::PATHS_NONE) begin
              res_nxt.status = rtt_pkg::STAT_NO_ROUTE;
            end else begin
              nb_rd_en   = 1'b1;
              nb_rd_addr = rt_q.first;
              state_nxt  = S_FETCH;
            end
          end
          rtt_pkg::CMD_QUERY: begin
            res_nxt.is_blacklisted = nb_q.black;
          end
          rtt_pkg::CMD_REMOVE_ADDR: begin
            nb_wr_en         = 1'b1;
            nb_wr_data.black = 1'b1;
            nb_wr_data.valid = nb_q.valid;
            nb_wr_data.port  = nb_q.port;
            rem_nxt          = tgt_r;
            sweep_nbr_nxt    = 1'b0;
            state_nxt        = S_SWEEP;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Resolve the best next hop to its port
      S_FETCH: begin
        if (!nb_q.valid) begin
          res_nxt.status = rtt_pkg::STAT_NO_NBR;
        end else begin
          res_nxt.out_port = rtt_pkg::FIELD_PORT_W'(nb_q.port);
        end
        state_nxt = S_DONE;
      end

      // Search neighbours in address order for the first one on the port
      S_SCAN: begin
        nb_rd_en    = !stop_r;
        pend_nxt    = !stop_r;
        wb_addr_nxt = idx_r;
        if (!stop_r) begin
          idx_nxt  = idx_r + ADDR_BITS'(1);
          stop_nxt = &idx_r;
        end
        if (scan_hit) begin
          nb_wr_en         = 1'b1;
          nb_wr_addr       = wb_addr_r;
          nb_wr_data.black = 1'b1;
          nb_wr_data.valid = 1'b0;
          nb_wr_data.port  = '0;
          rem_nxt          = wb_addr_r;
          idx_nxt          = '0;
          pend_nxt         = 1'b0;
          stop_nxt         = 1'b0;
          sweep_nbr_nxt    = 1'b0;
          state_nxt        = S_SWEEP;
        end else if (pend_r && stop_r) begin
          res_nxt.status = rtt_pkg::STAT_IGNORED;
          state_nxt      = S_DONE;
        end
      end

      // Read each entry and write it back modified in the following cycle
      S_SWEEP: begin
        pend_nxt    = !stop_r;
        wb_addr_nxt = idx_r;
        if (!stop_r) begin
          idx_nxt  = idx_r + ADDR_BITS'(1);
          stop_nxt = &idx_r;
        end
        if (sweep_nbr_r) begin
          nb_rd_en = !stop_r;
        end else begin
          rt_rd_en = !stop_r;
        end
        nb_wr_addr = wb_addr_r;
        rt_wr_addr = wb_addr_r;
        if (pend_r) begin
          if (sweep_nbr_r) begin
            nb_wr_en         = 1'b1;
            nb_wr_data.black = 1'b0;
            nb_wr_data.valid = nb_q.valid;
            nb_wr_data.port  = nb_q.port;
          end else begin
            rt_wr_en   = 1'b1;
            rt_wr_data = route_drop(rt_q, wb_addr_r, rem_r);
          end
        end
        if (pend_r && stop_r) begin
          state_nxt = S_DONE;
        end
      end

      // Hold the result until the output stage takes it
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      stop_r      <= 1'b0;
      install_r   <= 1'b0;
      sweep_nbr_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      stop_r      <= stop_nxt;
      install_r   <= install_nxt;
      sweep_nbr_r <= sweep_nbr_nxt;
      wb_addr_r   <= wb_addr_nxt;
      cmd_r       <= cmd_nxt;
      tgt_r       <= tgt_nxt;
      nxt_hop_r   <= nxt_hop_nxt;
      hop_r       <= hop_nxt;
      port_r      <= port_nxt;
      rem_r       <= rem_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

[hdl/two_path_route_table_core.sv]
// Top level of the two-path route table: configuration register, sequencer and output stage.
// One request at a time; sweeps are paced by the single read and write port of each
// memory. Reset: rst_n clears control state and my_address, then a clearing pass
// holds ready low.
module two_path_route_table_core #(
  parameter int ADDR_BITS = 8,
  parameter int PORT_BITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  rtt_req_if.sink    in_req,
  rtt_rsp_if.source  out_rsp,
  rtt_cfg_if.sink    cfg_wr
);

  logic [rtt_pkg::MY_ADDR_W-1:0] my_address_r;
  logic                          res_valid;
  logic                          res_ready;
  rtt_pkg::result_t              res;
  logic                          out_valid_r;
  rtt_pkg::result_t              out_res_r;
  logic                          busy_r;

  // Own address register, writable at any time
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_address_r <= '0;
    end else if (cfg_wr.valid) begin
      my_address_r <= cfg_wr.data;
    end
  end

  rtt_ctrl #(.ADDR_BITS(ADDR_BITS), .PORT_BITS(PORT_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .my_address (my_address_r),
    .req        (in_req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_res_r.status;
  assign out_rsp.out_port       = out_res_r.out_port;
  assign out_rsp.is_blacklisted = out_res_r.is_blacklisted;

  // Track a request in flight between acceptance and its result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_req.valid && in_req.ready) begin
      busy_r <= 1'b1;
    end else if (res_valid && res_ready) begin
      busy_r <= 1'b0;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |-> !busy_r)
    else $error("request accepted while another is in flight");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |-> busy_r)
    else $error("result produced without a request");

  a_black_only_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.is_blacklisted) |->
      (out_rsp.status == rtt_pkg::STAT_OK && out_rsp.out_port == '0))
    else $error("blacklist flag with a port or error status");

  a_port_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != rtt_pkg::STAT_OK) |-> out_rsp.out_port == '0)
    else $error("port reported with an error status");

endmodule

[dv/rtt_result_checker.sv]
// Route table result checker: mirrors the tables, predicts each result and compares it.
`timescale 1ns / 1ps

module rtt_result_checker
  import rtt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rtt_req_if   req,
  rtt_rsp_if   rsp,
  rtt_cfg_if   cfg,
  output int   mismatch_count,
  output int   replies_owed
);

  localparam int DEPTH = 1 << FIELD_ADDR_W;

  typedef logic [FIELD_ADDR_W-1:0] addr_t;
  typedef logic [FIELD_PORT_W-1:0] port_t;
  typedef logic [HOP_W-1:0]        hops_t;

  typedef struct packed {
    addr_t              first;
    hops_t              first_cost;
    addr_t              second;
    hops_t              second_cost;
    logic [PATHS_W-1:0] paths;
  } path_entry_t;

  path_entry_t routes [DEPTH];
  logic        nbr_valid [DEPTH];
  port_t       nbr_port [DEPTH];
  logic        barred [DEPTH];
  addr_t       node_addr;
  result_t     awaited_results [$];

  // Empty every table, blacklist included
  function automatic void wipe_tables();
    for (int a = 0; a < DEPTH; a++) begin
      routes[a].paths = PATHS_NONE;
      nbr_valid[a]    = 1'b0;
      nbr_port[a]     = '0;
      barred[a]       = 1'b0;
    end
  endfunction

  // Apply an advertised route under the two-path rules
  function automatic status_t learn_route(addr_t via, addr_t dest, hops_t hops);
    if (barred[dest]) return STAT_IGNORED;
    if (routes[dest].paths == PATHS_NONE) begin
      routes[dest].first      = via;
      routes[dest].first_cost = hops;
      routes[dest].paths      = PATHS_ONE;
    end else if (routes[dest].first_cost > hops) begin
      if (routes[dest].first == via) begin
        routes[dest].first_cost = hops;
      end else begin
        routes[dest].second      = routes[dest].first;
        routes[dest].second_cost = routes[dest].first_cost;
        routes[dest].first       = via;
        routes[dest].first_cost  = hops;
        routes[dest].paths       = PATHS_TWO;
      end
    end else if (routes[dest].paths == PATHS_TWO) begin
      if (routes[dest].second_cost > hops) begin
        routes[dest].second      = via;
        routes[dest].second_cost = hops;
      end
    end else if (routes[dest].first != via) begin
      routes[dest].second      = via;
      routes[dest].second_cost = hops;
      routes[dest].paths       = PATHS_TWO;
    end
    return STAT_OK;
  endfunction

  // Blacklist an address, drop routes to or via it and promote backups
  function automatic void withdraw_address(addr_t gone);
    barred[gone] = 1'b1;
    for (int d = 0; d < DEPTH; d++) begin
      if (routes[d].paths != PATHS_NONE) begin
        if (addr_t'(d) == gone) begin
          routes[d].paths = PATHS_NONE;
        end else if (routes[d].first == gone) begin
          if (routes[d].paths == PATHS_ONE) begin
            routes[d].paths = PATHS_NONE;
          end else begin
            routes[d].first      = routes[d].second;
            routes[d].first_cost = routes[d].second_cost;
            routes[d].paths      = PATHS_ONE;
          end
        end else if (routes[d].paths == PATHS_TWO && routes[d].second == gone) begin
          routes[d].paths = PATHS_ONE;
        end
      end
    end
  endfunction

  // Work out the result of one request and update the mirrored tables
  function automatic result_t apply_request(cmd_t op, addr_t tgt, addr_t via, hops_t hops,
                                            port_t prt);
    result_t r;
    logic    found;
    r.status         = STAT_OK;
    r.out_port       = '0;
    r.is_blacklisted = 1'b0;
    found            = 1'b0;
    case (op)
      CMD_INIT: begin
        wipe_tables();
        void'(learn_route(node_addr, node_addr, '0));
      end
      CMD_REGISTER: begin
        if (barred[tgt] || nbr_valid[tgt]) begin
          r.status = STAT_IGNORED;
        end else begin
          nbr_valid[tgt] = 1'b1;
          nbr_port[tgt]  = prt;
        end
      end
      CMD_REMOVE_PORT: begin
        r.status = STAT_IGNORED;
        for (int a = 0; a < DEPTH; a++) begin
          if (!found && nbr_valid[a] && nbr_port[a] == prt) begin
            found        = 1'b1;
            nbr_valid[a] = 1'b0;
            nbr_port[a]  = '0;
            withdraw_address(addr_t'(a));
            r.status     = STAT_OK;
          end
        end
      end
      CMD_UPDATE: r.status = learn_route(via, tgt, hops);
      CMD_FETCH: begin
        if (routes[tgt].paths == PATHS_NONE) begin
          r.status = STAT_NO_ROUTE;
        end else if (!nbr_valid[routes[tgt].first]) begin
          r.status = STAT_NO_NBR;
        end else begin
          r.out_port = nbr_port[routes[tgt].first];
        end
      end
      CMD_CLEAR_BL: begin
        for (int a = 0; a < DEPTH; a++) barred[a] = 1'b0;
      end
      CMD_QUERY: r.is_blacklisted = barred[tgt];
      CMD_REMOVE_ADDR: withdraw_address(tgt);
      default: ;
    endcase
    return r;
  endfunction

  // Match results against the oldest prediction, then predict any new request
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      wipe_tables();
      node_addr = '0;
      awaited_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) node_addr = cfg.data;
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", rsp.status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, rsp.status);
            mismatch_count++;
          end
          if (rsp.out_port !== want.out_port) begin
            $error("out_port expected %0d got %0d", want.out_port, rsp.out_port);
            mismatch_count++;
          end
          if (rsp.is_blacklisted !== want.is_blacklisted) begin
            $error("is_blacklisted expected %0d got %0d", want.is_blacklisted,
                   rsp.is_blacklisted);
            mismatch_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_results.push_back(apply_request(cmd_t'(req.command), req.target_address,
                                                req.next_hop, req.hop_count, req.port));
      end
    end
    replies_owed = awaited_results.size();
  end

endmodule

[dv/tb_two_path_route_table_core.sv]
// Top of the route table testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_two_path_route_table_core;
  import rtt_pkg::*;

  localparam int IDLE_LIMIT     = 5000;
  localparam int SETTLE_CYCLES  = 600;
  localparam int PHASE_REQUESTS = 280;

  typedef logic [FIELD_ADDR_W-1:0] addr_t;

  logic  clk;
  logic  rst_n;
  int    mismatch_count;
  int    replies_owed;
  int    quiet_cycles;
  bit    steady_flow;
  addr_t hot_addr [16];
  addr_t node_choice [6];

  rtt_req_if in_req ();
  rtt_rsp_if out_rsp ();
  rtt_cfg_if cfg_wr ();

  two_path_route_table_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  rtt_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (in_req),
    .rsp            (out_rsp),
    .cfg            (cfg_wr),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draw how long one side holds off before its next request or result
  function automatic int idle_draw();
    if (steady_flow || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Mostly a small pool of addresses so that routes and neighbours meet
  function automatic addr_t pick_addr();
    if ($urandom_range(0, 9) < 7) return hot_addr[4'($urandom_range(0, 15))];
    return addr_t'($urandom_range(0, 255));
  endfunction

  function automatic void fill_hot_pool(addr_t node);
    hot_addr[0] = node;
    hot_addr[1] = 8'h00;
    hot_addr[2] = 8'hFF;
    for (int i = 3; i < 16; i++) hot_addr[i] = addr_t'($urandom_range(0, 255));
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic issue(input cmd_t op, input addr_t tgt, input addr_t via,
                       input logic [HOP_W-1:0] hops, input logic [FIELD_PORT_W-1:0] prt);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.command        <= op;
    in_req.target_address <= tgt;
    in_req.next_hop       <= via;
    in_req.hop_count      <= hops;
    in_req.port           <= prt;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Drop valid and wait until every request has its result
  task automatic drain();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  // Write this node's address while idle, then install it with init
  task automatic set_node_address(input addr_t node);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= node;
    do @(posedge clk); while (!cfg_wr.ready);
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
    fill_hot_pool(node);
    issue(CMD_INIT, node, node, '0, '0);
  endtask

  // One random request: mostly well-formed traffic, some pure noise
  task automatic random_request();
    int                      roll;
    cmd_t                    op;
    logic [HOP_W-1:0]        hops;
    logic [FIELD_PORT_W-1:0] prt;
    roll = $urandom_range(0, 99);
    hops = ($urandom_range(0, 3) == 0) ? HOP_W'($urandom_range(0, 255))
                                       : HOP_W'($urandom_range(0, 12));
    prt  = FIELD_PORT_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      issue(cmd_t'($urandom_range(0, 7)), addr_t'($urandom_range(0, 255)),
            addr_t'($urandom_range(0, 255)), hops, prt);
    end else begin
      if (roll < 2)       op = CMD_INIT;
      else if (roll < 18) op = CMD_REGISTER;
      else if (roll < 23) op = CMD_REMOVE_PORT;
      else if (roll < 57) op = CMD_UPDATE;
      else if (roll < 82) op = CMD_FETCH;
      else if (roll < 87) op = CMD_CLEAR_BL;
      else if (roll < 95) op = CMD_QUERY;
      else                op = CMD_REMOVE_ADDR;
      issue(op, pick_addr(), pick_addr(), hops, prt);
    end
  endtask

  // Result side: stall a random while, then accept one result
  initial begin
    out_rsp.ready = 1'b0;
    forever begin : accept_result
      int stall;
      stall = idle_draw();
      @(negedge clk);
      if (stall > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!(out_rsp.valid && out_rsp.ready));
    end
  end

  // End the run when nothing has been accepted for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
          (cfg_wr.valid && cfg_wr.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("two_path_route_table_core regression: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst_n                 = 1'b0;
    steady_flow           = 1'b0;
    in_req.valid          = 1'b0;
    in_req.command        = CMD_INIT;
    in_req.target_address = '0;
    in_req.next_hop       = '0;
    in_req.hop_count      = '0;
    in_req.port           = '0;
    cfg_wr.valid          = 1'b0;
    cfg_wr.data           = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: self route, both paths, promotion, blacklist and removal cases
    set_node_address(8'hFF);
    issue(CMD_FETCH,       8'hFF, 8'h00, 8'd0,   4'd0);
    issue(CMD_FETCH,       8'h00, 8'h00, 8'd0,   4'd0);
    issue(CMD_REGISTER,    8'h10, 8'h00, 8'd0,   4'd15);
    issue(CMD_REGISTER,    8'h10, 8'h00, 8'd0,   4'd4);
    issue(CMD_REGISTER,    8'h00, 8'h00, 8'd0,   4'd0);
    issue(CMD_UPDATE,      8'h40, 8'h10, 8'd5,   4'd0);
    issue(CMD_FETCH,       8'h40, 8'h00, 8'd0,   4'd0);
    issue(CMD_UPDATE,      8'h40, 8'h00, 8'd3,   4'd0);
    issue(CMD_UPDATE,      8'h40, 8'h00, 8'd1,   4'd0);
    issue(CMD_UPDATE,      8'h40, 8'h20, 8'd255, 4'd0);
    issue(CMD_UPDATE,      8'h40, 8'h20, 8'd2,   4'd0);
    issue(CMD_UPDATE,      8'h80, 8'h10, 8'd0,   4'd0);
    issue(CMD_UPDATE,      8'h80, 8'h00, 8'd0,   4'd0);
    issue(CMD_UPDATE,      8'hFF, 8'h10, 8'd255, 4'd0);
    issue(CMD_REMOVE_ADDR, 8'h00, 8'h00, 8'd0,   4'd0);
    issue(CMD_FETCH,       8'h40, 8'h00, 8'd0,   4'd0);
    issue(CMD_QUERY,       8'h00, 8'h00, 8'd0,   4'd0);
    issue(CMD_QUERY,       8'h10, 8'h00, 8'd0,   4'd0);
    issue(CMD_REGISTER,    8'h00, 8'h00, 8'd0,   4'd3);
    issue(CMD_UPDATE,      8'h00, 8'h10, 8'd1,   4'd0);
    issue(CMD_REMOVE_PORT, 8'h00, 8'h00, 8'd0,   4'd15);
    issue(CMD_REMOVE_PORT, 8'h00, 8'h00, 8'd0,   4'd9);
    issue(CMD_FETCH,       8'h80, 8'h00, 8'd0,   4'd0);
    issue(CMD_CLEAR_BL,    8'h00, 8'h00, 8'd0,   4'd0);
    issue(CMD_QUERY,       8'h00, 8'h00, 8'd0,   4'd0);
    drain();

    // Random phases, each with its own node address
    node_choice[0] = 8'h00;
    node_choice[1] = 8'hFF;
    node_choice[2] = addr_t'($urandom_range(0, 255));
    node_choice[3] = 8'h80;
    node_choice[4] = 8'h7F;
    node_choice[5] = addr_t'($urandom_range(0, 255));
    foreach (node_choice[p]) begin
      set_node_address(node_choice[p]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        random_request();
      end
      drain();
    end

    steady_flow = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && replies_owed == 0)
      $display("two_path_route_table_core regression: pass");
    else
      $display("two_path_route_table_core regression: fail");
    $finish;
  end

endmodule

[sim.f]
hdl/rtt_pkg.sv
hdl/rtt_if.sv
hdl/rtt_ram.sv
hdl/rtt_ctrl.sv
hdl/two_path_route_table_core.sv
dv/rtt_result_checker.sv
dv/tb_two_path_route_table_core.sv
